@@ src/bpfp_pkg.sv @@
`timescale 1ns / 1ps

package bpfp_pkg;

    // Default palette size
    localparam int PALETTE_DEPTH_DEF = 256;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT   = 1'd1;

    // Source format codes
    localparam logic [2:0] SRC_FMT_1   = 3'd0;
    localparam logic [2:0] SRC_FMT_2   = 3'd1;
    localparam logic [2:0] SRC_FMT_4   = 3'd2;
    localparam logic [2:0] SRC_FMT_8   = 3'd3;
    localparam logic [2:0] SRC_FMT_16  = 3'd4;
    localparam logic [2:0] SRC_FMT_24  = 3'd5;
    localparam logic [2:0] SRC_FMT_32  = 3'd6;

    // Destination format codes
    localparam logic [2:0] DST_FMT_1   = 3'd0;
    localparam logic [2:0] DST_FMT_2   = 3'd1;
    localparam logic [2:0] DST_FMT_4   = 3'd2;
    localparam logic [2:0] DST_FMT_8   = 3'd3;
    localparam logic [2:0] DST_FMT_15  = 3'd4;
    localparam logic [2:0] DST_FMT_16  = 3'd5;
    localparam logic [2:0] DST_FMT_24  = 3'd6;
    localparam logic [2:0] DST_FMT_32  = 3'd7;

    // Input action codes
    localparam logic ACT_PALETTE_WRITE = 1'b0;
    localparam logic ACT_CONVERT       = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] pixel_value;
        logic        row_end;
        logic [7:0]  palette_index;
        logic [31:0] palette_word;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_last;
    } pix_out_t;

    // One converted pixel: data bytes first, then zero padding
    typedef struct packed {
        logic [3:0][7:0] data_bytes;
        logic [2:0]      n_data;
        logic [2:0]      n_total;
        logic            row_end;
    } job_t;

endpackage

@@ src/bpfp_front.sv @@
`timescale 1ns / 1ps

module bpfp_front
    import bpfp_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pix_in_t               in_data,
    output logic                  push_valid,
    input  logic                  push_full,
    output job_t                  push_job
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [2:0]  src_fmt_reg;
    logic [2:0]  dst_fmt_reg;

    logic [31:0] pal_mem [PALETTE_DEPTH];
    logic [31:0] pal_rdata_reg;

    logic        s1_valid_reg;
    logic [31:0] s1_sv_reg;
    logic        s1_row_end_reg;
    logic        s1_pal_ok_reg;

    logic [7:0]  acc_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  phase_reg;
    logic [7:0]  acc_next;
    logic [2:0]  cnt_next;
    logic [1:0]  phase_next;

    logic        accept;
    logic        accept_conv;
    logic        accept_pal;
    logic        s1_adv;
    logic [31:0] sv_masked;
    logic        has_bytes;
    job_t        job;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= SRC_FMT_8;
            dst_fmt_reg <= DST_FMT_8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: src_fmt_reg <= cfg_data;
                REG_DEST_FORMAT:   dst_fmt_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Mask the raw code to the source depth
    always_comb
    begin
        case (src_fmt_reg)
            SRC_FMT_1:  sv_masked = {31'd0, in_data.pixel_value[0]};
            SRC_FMT_2:  sv_masked = {30'd0, in_data.pixel_value[1:0]};
            SRC_FMT_4:  sv_masked = {28'd0, in_data.pixel_value[3:0]};
            SRC_FMT_8:  sv_masked = {24'd0, in_data.pixel_value[7:0]};
            SRC_FMT_16: sv_masked = {16'd0, in_data.pixel_value[15:0]};
            SRC_FMT_24: sv_masked = {8'd0, in_data.pixel_value[23:0]};
            default:    sv_masked = in_data.pixel_value;
        endcase
    end

    assign in_stall    = s1_valid_reg && !s1_adv;
    assign accept      = in_valid && !in_stall;
    assign accept_conv = accept && (in_data.action == ACT_CONVERT);
    assign accept_pal  = accept && (in_data.action == ACT_PALETTE_WRITE);

    // Write and read the palette
    always_ff @(posedge clk)
    begin
        if (accept_pal && ({1'b0, in_data.palette_index} < 9'(PALETTE_DEPTH)))
        begin
            pal_mem[in_data.palette_index[PAL_AW-1:0]] <= in_data.palette_word;
        end
        if (accept_conv)
        begin
            pal_rdata_reg <= pal_mem[sv_masked[PAL_AW-1:0]];
        end
    end

    // Hold the item under conversion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept_conv)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_conv)
        begin
            s1_sv_reg      <= sv_masked;
            s1_row_end_reg <= in_data.row_end;
            s1_pal_ok_reg  <= {1'b0, sv_masked[7:0]} < 9'(PALETTE_DEPTH);
        end
    end

    // Convert the pixel and pack it into bytes
    always_comb
    begin
        logic        indexed;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] c;
        logic [14:0] w;
        logic [11:0] grey;
        logic [3:0]  dbits;
        logic [3:0]  v;
        logic [7:0]  vtop;
        logic        pre;
        logic [7:0]  acc_a;
        logic [2:0]  cnt_a;
        logic [7:0]  acc_b;
        logic [3:0]  cnt_b;
        logic        full;
        logic        e2;
        logic [2:0]  n;
        logic [1:0]  pad;

        indexed = (src_fmt_reg == SRC_FMT_1) || (src_fmt_reg == SRC_FMT_2) ||
                  (src_fmt_reg == SRC_FMT_4) || (src_fmt_reg == SRC_FMT_8);

        if (src_fmt_reg == SRC_FMT_16)
        begin
            b = {s1_sv_reg[4:0], 3'd0};
            g = {s1_sv_reg[9:5], 3'd0};
            r = {s1_sv_reg[14:10], 3'd0};
        end
        else
        begin
            b = s1_sv_reg[7:0];
            g = s1_sv_reg[15:8];
            r = s1_sv_reg[23:16];
        end

        // True colour word
        if (indexed)
            c = s1_pal_ok_reg ? pal_rdata_reg : 32'd0;
        else if (src_fmt_reg == SRC_FMT_16)
            c = {s1_sv_reg[15], 7'd0, r, g, b};
        else if (src_fmt_reg == SRC_FMT_24)
            c = {8'd0, s1_sv_reg[23:0]};
        else
            c = s1_sv_reg;

        w    = {c[23:19], c[15:11], c[7:3]};
        grey = ({4'd0, g} << 3) + {4'd0, g} + ({4'd0, r} << 2) + {4'd0, r} +
               {3'd0, b, 1'b0};

        job        = '0;
        job.row_end = s1_row_end_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        n          = 3'd0;

        // Sub-byte path defaults, used only for depths below eight bits
        case (dst_fmt_reg)
            DST_FMT_1: dbits = 4'd1;
            DST_FMT_2: dbits = 4'd2;
            default:   dbits = 4'd4;
        endcase
        case (dst_fmt_reg)
            DST_FMT_1: v = indexed ? {3'd0, s1_sv_reg[0]} : {3'd0, (s1_sv_reg != 32'd0)};
            DST_FMT_2: v = indexed ? {2'd0, s1_sv_reg[1:0]} : {2'd0, grey[11:10]};
            default:   v = indexed ? s1_sv_reg[3:0] : grey[11:8];
        endcase
        case (dst_fmt_reg)
            DST_FMT_1: vtop = {v[0], 7'd0};
            DST_FMT_2: vtop = {v[1:0], 6'd0};
            default:   vtop = {v[3:0], 4'd0};
        endcase
        pre   = ({1'b0, cnt_reg} + dbits) > 4'd8;
        acc_a = pre ? 8'd0 : acc_reg;
        cnt_a = pre ? 3'd0 : cnt_reg;
        acc_b = acc_a | (vtop >> cnt_a);
        cnt_b = {1'b0, cnt_a} + dbits;
        full  = cnt_b >= 4'd8;
        e2    = full || (s1_row_end_reg && (cnt_b != 4'd0));

        case (dst_fmt_reg)
            DST_FMT_15, DST_FMT_16:
            begin
                job.data_bytes[0] = w[7:0];
                job.data_bytes[1] = {(dst_fmt_reg == DST_FMT_15) && (c[31:24] != 8'd0),
                                     w[14:8]};
                n        = 3'd2;
                acc_next = 8'd0;
                cnt_next = 3'd0;
            end
            DST_FMT_24, DST_FMT_32:
            begin
                job.data_bytes[0] = c[7:0];
                job.data_bytes[1] = c[15:8];
                job.data_bytes[2] = c[23:16];
                job.data_bytes[3] = c[31:24];
                n        = (dst_fmt_reg == DST_FMT_32) ? 3'd4 : 3'd3;
                acc_next = 8'd0;
                cnt_next = 3'd0;
            end
            DST_FMT_8:
            begin
                job.data_bytes[0] = indexed ? s1_sv_reg[7:0] : {g[7:5], r[7:5], b[7:6]};
                n        = 3'd1;
                acc_next = 8'd0;
                cnt_next = 3'd0;
            end
            default:
            begin
                // Flush a partial byte that cannot take the pixel, then the new byte
                if (pre)
                begin
                    job.data_bytes[0] = acc_reg;
                    job.data_bytes[1] = acc_b;
                end
                else
                begin
                    job.data_bytes[0] = acc_b;
                end
                n        = {2'd0, pre} + {2'd0, e2};
                acc_next = e2 ? 8'd0 : acc_b;
                cnt_next = e2 ? 3'd0 : cnt_b[2:0];
            end
        endcase

        // Pad the row to a four-byte boundary on row end
        pad = s1_row_end_reg ? 2'(3'd0 - (3'(phase_reg) + n)) : 2'd0;
        job.n_data  = n;
        job.n_total = n + 3'(pad);
        phase_next  = s1_row_end_reg ? 2'd0 : 2'(3'(phase_reg) + n);
        has_bytes   = job.n_total != 3'd0;
    end

    assign s1_adv     = s1_valid_reg && (!push_full || !has_bytes);
    assign push_valid = s1_valid_reg && has_bytes;
    assign push_job   = job;

    // Advance packer state as each pixel leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 8'd0;
            cnt_reg   <= 3'd0;
            phase_reg <= 2'd0;
        end
        else if (s1_adv)
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ src/bpfp_queue.sv @@
`timescale 1ns / 1ps

module bpfp_queue
    import bpfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_full,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_full = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop && pop_valid;
    assign pop_job   = slot_reg[rd_ptr_reg];

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ src/bpfp_back.sv @@
`timescale 1ns / 1ps

module bpfp_back
    import bpfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  job_t     job,
    output logic     job_pop,
    output logic     out_valid,
    input  logic     out_stall,
    output pix_out_t out_data
);

    logic [2:0] idx_reg;
    logic       out_valid_reg;
    pix_out_t   out_data_reg;
    logic       load;
    logic       last;
    pix_out_t   beat;

    assign load    = job_valid && (!out_valid_reg || !out_stall);
    assign last    = idx_reg == (job.n_total - 3'd1);
    assign job_pop = load && last;

    // Pick data byte or padding
    always_comb
    begin
        beat.out_byte = (idx_reg < job.n_data) ? job.data_bytes[idx_reg[1:0]] : 8'd0;
        beat.row_last = job.row_end && last;
    end

    // Walk through the bytes of the head job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg       <= last ? 3'd0 : idx_reg + 3'd1;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/bmp_pixel_format_packer.sv @@
`timescale 1ns / 1ps
// An accepted pixel is held in the front stage register, queued as a job, then shown from the output register.
// Throughput: one input beat per cycle while the queue has room; one output byte per cycle
// while out_stall is low. A pixel yields up to four data bytes plus up to three padding bytes.
// Reset: formats return to 8 bit, packer and queue clear; palette contents stay undefined.
module bmp_pixel_format_packer
    import bpfp_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pix_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pix_out_t              out_data
);

    logic push_valid;
    logic push_full;
    job_t push_job;
    logic pop_valid;
    logic pop;
    job_t pop_job;

    // Accept, convert and pack
    bpfp_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_job   (push_job)
    );

    // Decouple front from back
    bpfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    // Serialise bytes to the output
    bpfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bpfp_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_SEGS    = 24;
    localparam int SEG_BEATS      = 18;

    // Format code 7 on the source side behaves as 32 bit
    localparam logic [2:0] SRC_FMT_ALIAS_32 = 3'd7;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    // Predicts the byte stream of the packer and checks it beat by beat
    class pixel_byte_predictor;
        logic [2:0]  src_fmt;
        logic [2:0]  dst_fmt;
        logic [7:0]  acc;
        int          fill_bits;
        logic [1:0]  row_phase;
        logic [31:0] palette [256];
        bit          palette_known [256];
        logic [7:0]  want_byte [$];
        bit          want_last [$];
        int          item_bytes;
        int          errors;
        int          checked;
        int          rows_closed;

        function new();
            src_fmt   = SRC_FMT_8;
            dst_fmt   = DST_FMT_8;
            acc       = '0;
            fill_bits = 0;
            row_phase = '0;
            errors    = 0;
            checked   = 0;
            rows_closed = 0;
            foreach (palette_known[i]) palette_known[i] = 1'b0;
        endfunction

        static function int src_depth(logic [2:0] fmt);
            case (fmt)
                SRC_FMT_1:  return 1;
                SRC_FMT_2:  return 2;
                SRC_FMT_4:  return 4;
                SRC_FMT_8:  return 8;
                SRC_FMT_16: return 16;
                SRC_FMT_24: return 24;
                default:    return 32;
            endcase
        endfunction

        static function int dst_depth(logic [2:0] fmt);
            case (fmt)
                DST_FMT_1:  return 1;
                DST_FMT_2:  return 2;
                DST_FMT_4:  return 4;
                DST_FMT_8:  return 8;
                DST_FMT_15: return 15;
                DST_FMT_16: return 16;
                DST_FMT_24: return 24;
                default:    return 32;
            endcase
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_SOURCE_FORMAT)
                src_fmt = val;
            else
                dst_fmt = val;
        endfunction

        function void push_byte(logic [7:0] val);
            want_byte.push_back(val);
            want_last.push_back(1'b0);
            row_phase  = row_phase + 2'd1;
            item_bytes = item_bytes + 1;
        endfunction

        // Work out the bytes that one accepted input beat causes
        function void note_pixel_beat(pix_in_t beat);
            int          sbits;
            int          dbits;
            int          r;
            int          g;
            int          b;
            int          v;
            int          mask;
            bit          indexed;
            logic [31:0] sv;
            logic [31:0] colour;
            logic [15:0] w;

            if (beat.action == ACT_PALETTE_WRITE)
            begin
                palette[beat.palette_index]       = beat.palette_word;
                palette_known[beat.palette_index] = 1'b1;
            end
            else
            begin
                item_bytes = 0;
                sbits = src_depth(src_fmt);
                dbits = dst_depth(dst_fmt);
                sv = beat.pixel_value;
                if (sbits < 32)
                    sv = sv & ((32'd1 << sbits) - 32'd1);
                indexed = (sbits <= 8);

                // split the colour of direct sources
                if (sbits == 16)
                begin
                    b = int'(sv[4:0]) << 3;
                    g = int'(sv[9:5]) << 3;
                    r = int'(sv[14:10]) << 3;
                end
                else
                begin
                    b = int'(sv[7:0]);
                    g = int'(sv[15:8]);
                    r = int'(sv[23:16]);
                end

                if (dbits >= 15)
                begin
                    // true colour: look up or rebuild ARGB
                    if (indexed)
                        colour = palette[sv[7:0]];
                    else if (sbits == 16)
                        colour = {sv[15], 7'd0, 8'(r), 8'(g), 8'(b)};
                    else if (sbits == 24)
                        colour = {8'd0, sv[23:0]};
                    else
                        colour = sv;
                    acc = '0;
                    fill_bits = 0;
                    if (dbits <= 16)
                    begin
                        w = {1'b0, colour[23:19], colour[15:11], colour[7:3]};
                        if (dbits == 15 && colour[31:24] != 8'd0)
                            w[15] = 1'b1;
                        push_byte(w[7:0]);
                        push_byte(w[15:8]);
                    end
                    else
                    begin
                        push_byte(colour[7:0]);
                        push_byte(colour[15:8]);
                        push_byte(colour[23:16]);
                        if (dbits == 32)
                            push_byte(colour[31:24]);
                    end
                end
                else if (dbits == 8)
                begin
                    // 8 bit: index through, else G3R3B2
                    if (indexed)
                        v = int'(sv[7:0]);
                    else
                        v = ((g >> 5) << 5) | ((r >> 5) << 2) | (b >> 6);
                    acc = '0;
                    fill_bits = 0;
                    push_byte(8'(v));
                end
                else
                begin
                    // sub-byte: low bits, nonzero test or weighted grey
                    mask = (1 << dbits) - 1;
                    if (dbits == 1)
                        v = indexed ? int'(sv[0]) : int'(sv != 32'd0);
                    else if (indexed)
                        v = int'(sv) & mask;
                    else
                        v = ((g * 9 + r * 5 + b * 2) >> (12 - dbits)) & mask;
                    if (fill_bits + dbits > 8)
                    begin
                        push_byte(acc);
                        acc = '0;
                        fill_bits = 0;
                    end
                    acc = 8'((int'(acc) | (v << (8 - fill_bits - dbits))) & 255);
                    fill_bits = fill_bits + dbits;
                    if (fill_bits >= 8)
                    begin
                        push_byte(acc);
                        acc = '0;
                        fill_bits = 0;
                    end
                end

                // close the row: flush partial byte, pad to a four-byte boundary
                if (beat.row_end)
                begin
                    if (fill_bits != 0)
                    begin
                        push_byte(acc);
                        acc = '0;
                        fill_bits = 0;
                    end
                    while (row_phase != 2'd0)
                        push_byte(8'd0);
                    if (item_bytes > 0)
                        want_last[want_last.size() - 1] = 1'b1;
                    rows_closed++;
                end
            end
        endfunction

        // Compare one output beat with the oldest expected byte
        function void check_out_beat(pix_out_t got);
            logic [7:0] exp_byte;
            bit         exp_last;

            if (want_byte.size() == 0)
            begin
                $display("%0t: unexpected output beat, expected none, actual byte %h last %b",
                         $time, got.out_byte, got.row_last);
                errors++;
            end
            else
            begin
                exp_byte = want_byte.pop_front();
                exp_last = want_last.pop_front();
                checked++;
                if (got.out_byte !== exp_byte)
                begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, exp_byte, got.out_byte);
                    errors++;
                end
                if (got.row_last !== exp_last)
                begin
                    $display("%0t: row_last mismatch, expected %b, actual %b",
                             $time, exp_last, got.row_last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SOURCE_FORMAT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    pix_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pix_out_t              out_data;

    pixel_byte_predictor   sb;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    quiet_cycles  = 0;
    int                    beats_sent    = 0;
    int                    settings_used = 0;

    bmp_pixel_format_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Stall the output side at random
    always @(negedge clk)
    begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // Check every accepted output beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            sb.check_out_beat(out_data);
    end

    // Give up when no beat moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("[bmp_pixel_format_packer] ERROR");
            $finish;
        end
    end

    function automatic pix_in_t make_convert(logic [31:0] pixel, logic row_end);
        pix_in_t beat;
        beat.action        = ACT_CONVERT;
        beat.pixel_value   = pixel;
        beat.row_end       = row_end;
        beat.palette_index = 8'($urandom);
        beat.palette_word  = $urandom;
        return beat;
    endfunction

    function automatic pix_in_t make_palette_write(logic [7:0] idx, logic [31:0] word,
                                                   logic row_end);
        pix_in_t beat;
        beat.action        = ACT_PALETTE_WRITE;
        beat.pixel_value   = $urandom;
        beat.row_end       = row_end;
        beat.palette_index = idx;
        beat.palette_word  = word;
        return beat;
    endfunction

    function automatic void set_idling(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 78; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 78; end
            IDLE_BOTH:     begin send_idle_pct = 28; stall_pct = 28; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    // Drive one input beat, holding it until the block takes it
    task automatic send_beat(input pix_in_t beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_pixel_beat(beat);
        beats_sent++;
        @(negedge clk);
    endtask

    // Hold off until every expected byte is out and the block has settled
    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.want_byte.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_formats(input logic [2:0] src, input logic [2:0] dst);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = REG_SOURCE_FORMAT;
        cfg_data  = src;
        @(negedge clk);
        cfg_index = REG_DEST_FORMAT;
        cfg_data  = dst;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(REG_SOURCE_FORMAT, src);
        sb.write_reg(REG_DEST_FORMAT, dst);
        settings_used++;
    endtask

    // Random beat; palette entries are written before any true-colour lookup
    task automatic send_random_beat();
        pix_in_t    beat;
        int         sbits;
        int         dbits;
        logic [7:0] idx;

        sbits = pixel_byte_predictor::src_depth(sb.src_fmt);
        dbits = pixel_byte_predictor::dst_depth(sb.dst_fmt);
        beat = make_convert($urandom, ($urandom_range(0, 5) == 0));
        case ($urandom_range(0, 7))
            0:       beat.pixel_value = '0;
            1:       beat.pixel_value = '1;
            default: beat.pixel_value = $urandom;
        endcase
        if ($urandom_range(0, 99) < 12)
        begin
            beat.action = ACT_PALETTE_WRITE;
            send_beat(beat);
        end
        else
        begin
            if (sbits <= 8 && dbits >= 15)
            begin
                idx = 8'(beat.pixel_value & ((32'd1 << sbits) - 32'd1));
                if (!sb.palette_known[idx])
                    send_beat(make_palette_write(idx, $urandom, 1'($urandom)));
            end
            send_beat(beat);
        end
    endtask

    initial
    begin
        logic [2:0] src;
        logic [2:0] dst;

        sb = new();
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: palette, every depth, extremes and depth changes
        set_idling(IDLE_NONE);
        set_formats(SRC_FMT_8, DST_FMT_8);
        send_beat(make_palette_write(8'd0, 32'hFFFF_FFFF, 1'b1));
        send_beat(make_palette_write(8'd255, 32'h8012_3456, 1'b0));
        send_beat(make_palette_write(8'd1, 32'h00AB_CDEF, 1'b1));
        send_beat(make_convert(32'hFFFF_FF00, 1'b0));
        send_beat(make_convert(32'h0000_00FF, 1'b1));

        set_formats(SRC_FMT_1, DST_FMT_1);
        send_beat(make_convert(32'h0000_0001, 1'b0));
        send_beat(make_convert(32'hFFFF_FFFE, 1'b0));
        send_beat(make_convert(32'hFFFF_FFFF, 1'b0));
        send_beat(make_convert(32'h0000_0001, 1'b1));

        // one byte into the row, then a 32-bit pixel with the widest padding
        set_formats(SRC_FMT_32, DST_FMT_8);
        send_beat(make_convert(32'h00E0_E0C0, 1'b0));
        set_formats(SRC_FMT_32, DST_FMT_32);
        send_beat(make_convert(32'hFFFF_FFFF, 1'b1));

        set_formats(SRC_FMT_16, DST_FMT_15);
        send_beat(make_convert(32'h0000_FFFF, 1'b0));
        send_beat(make_convert(32'hFFFF_7FFF, 1'b1));
        set_formats(SRC_FMT_16, DST_FMT_16);
        send_beat(make_convert(32'h0000_8421, 1'b1));
        set_formats(SRC_FMT_24, DST_FMT_24);
        send_beat(make_convert(32'hFF12_3456, 1'b1));

        set_formats(SRC_FMT_ALIAS_32, DST_FMT_4);
        send_beat(make_convert(32'hFFFF_FFFF, 1'b0));
        send_beat(make_convert(32'h0000_0001, 1'b1));

        set_formats(SRC_FMT_8, DST_FMT_32);
        send_beat(make_convert(32'h1234_56FF, 1'b0));
        send_beat(make_convert(32'h0000_0001, 1'b1));

        // leave six bits pending, then a pixel that does not fit, then a byte
        set_formats(SRC_FMT_2, DST_FMT_2);
        send_beat(make_convert(32'h0000_0003, 1'b0));
        send_beat(make_convert(32'h0000_0001, 1'b0));
        send_beat(make_convert(32'h0000_0002, 1'b0));
        set_formats(SRC_FMT_4, DST_FMT_4);
        send_beat(make_convert(32'h0000_000F, 1'b0));
        set_formats(SRC_FMT_8, DST_FMT_8);
        send_beat(make_convert(32'h0000_005A, 1'b1));

        // Random segments, each under its own formats and idling
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            case (seg)
                0:       begin src = SRC_FMT_1;  dst = DST_FMT_1;  end
                1:       begin src = SRC_FMT_32; dst = DST_FMT_32; end
                2:       begin src = SRC_FMT_1;  dst = DST_FMT_32; end
                3:       begin src = SRC_FMT_32; dst = DST_FMT_1;  end
                default:
                begin
                    src = ($urandom_range(0, 9) == 0) ? SRC_FMT_ALIAS_32
                                                      : 3'($urandom_range(0, 6));
                    dst = 3'($urandom_range(0, 7));
                end
            endcase
            set_formats(src, dst);
            set_idling(idle_mode_t'(seg % 4));
            for (int k = 0; k < SEG_BEATS; k++)
                send_random_beat();
        end

        // Drain and settle
        set_idling(IDLE_NONE);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Drove %0d input beats under %0d format settings.",
                 beats_sent, settings_used);
        $display("Checked %0d output bytes over %0d padded rows, %0d errors.",
                 sb.checked, sb.rows_closed, sb.errors);
        if (sb.errors == 0)
            $display("[bmp_pixel_format_packer] OK");
        else
            $display("[bmp_pixel_format_packer] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/bpfp_pkg.sv
src/bpfp_front.sv
src/bpfp_queue.sv
src/bpfp_back.sv
src/bmp_pixel_format_packer.sv
tb/testbench.sv
